// ===== rtl/psu_pkg.sv =====
package psu_pkg;

  // Default sizing of the line store
  localparam int unsigned MaxWidthDef = 4096;
  localparam int unsigned MaxBppDef   = 4;

  localparam int unsigned RowWidthW = 13;
  localparam int unsigned BppW      = 3;
  localparam int unsigned CfgDataW  = RowWidthW;

  typedef enum logic [2:0] {
    FILT_NONE  = 3'd0,
    FILT_SUB   = 3'd1,
    FILT_UP    = 3'd2,
    FILT_AVG   = 3'd3,
    FILT_PAETH = 3'd4,
    FILT_BAD   = 3'd5
  } filter_e;

  typedef enum logic [0:0] {
    CFG_ROW_WIDTH = 1'b0,
    CFG_BPP       = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       image_start;
  } in_t;

  typedef struct packed {
    logic [7:0] pixel_byte;
    logic       row_last;
    logic       filter_bad;
  } out_t;

endpackage

// ===== rtl/png_scanline_unfilter.sv =====
// Channel | Dir | Handshake                   | Payload
// ------- | --- | --------------------------- | ----------------------------------------------
// in      | in  | in_valid_i / in_ready_o     | in_data_i  (in_byte, image_start)
// out     | out | out_valid_o / out_ready_i   | out_data_o (pixel_byte, row_last, filter_bad)
// cfg     | in  | cfg_we_i (no wait)          | cfg_idx_i, cfg_wdata_i
//
// One word can be taken in every cycle. A pixel word is registered in the working
// stage (line store read data, prediction, modulo-256 add), then sits in the output
// register until taken. Filter type words are consumed at acceptance and produce
// nothing. A stalled output holds the output register; the working stage then holds
// too and in_ready_o drops.
// Reset clears control and history state only; the line store is not cleared.
module png_scanline_unfilter #(
  parameter int unsigned MAX_WIDTH = psu_pkg::MaxWidthDef,
  parameter int unsigned MAX_BPP   = psu_pkg::MaxBppDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  psu_pkg::in_t                  in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output psu_pkg::out_t                 out_data_o,
  input  logic                          cfg_we_i,
  input  logic [0:0]                    cfg_idx_i,
  input  logic [psu_pkg::CfgDataW-1:0]  cfg_wdata_i
);

  // Store depth and counter widths. The column counter must reach 4 * MAX_WIDTH - 1,
  // since any pixel size other than three is taken as four bytes.
  localparam int unsigned Depth = MAX_WIDTH * MAX_BPP;
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned ColW  = $clog2(MAX_WIDTH * 4);
  localparam int unsigned LenW  = $clog2(MAX_WIDTH * 4 + 1);

  // Row length in bytes, from a clamped width and the effective pixel size.
  function automatic logic [LenW-1:0] row_len(
    logic [psu_pkg::RowWidthW-1:0] w,
    logic [psu_pkg::BppW-1:0]      bpp
  );
    logic [LenW-1:0] wc;
    if (w == '0) begin
      wc = LenW'(1);
    end else if (32'(w) > MAX_WIDTH) begin
      wc = LenW'(MAX_WIDTH);
    end else begin
      wc = LenW'(w);
    end
    if (bpp == psu_pkg::BppW'(3)) begin
      return wc + (wc << 1);
    end else begin
      return wc << 2;
    end
  endfunction

  function automatic logic [9:0] abs_diff(logic [9:0] x, logic [9:0] y);
    return (x >= y) ? (x - y) : (y - x);
  endfunction

  function automatic logic [7:0] paeth(logic [7:0] a, logic [7:0] b, logic [7:0] c);
    logic [9:0] pa;
    logic [9:0] pb;
    logic [9:0] pc;
    pa = abs_diff(10'(b), 10'(c));
    pb = abs_diff(10'(a), 10'(c));
    pc = abs_diff(10'(a) + 10'(b), 10'(c) + 10'(c));
    if (pa <= pb && pa <= pc) begin
      return a;
    end else if (pb <= pc) begin
      return b;
    end else begin
      return c;
    end
  endfunction

  // ---------------------------------------------------------------------
  // Configuration: keep the row length ready so acceptance needs only a compare
  // ---------------------------------------------------------------------
  logic [psu_pkg::RowWidthW-1:0] width_q;
  logic [psu_pkg::BppW-1:0]      bpp_q;
  logic [LenW-1:0]               len_q;
  logic                          bpp3;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= psu_pkg::RowWidthW'(1);
      bpp_q   <= psu_pkg::BppW'(4);
      len_q   <= LenW'(4);
    end else if (cfg_we_i) begin
      case (psu_pkg::cfg_reg_e'(cfg_idx_i))
        psu_pkg::CFG_ROW_WIDTH: begin
          width_q <= cfg_wdata_i;
          len_q   <= row_len(cfg_wdata_i, bpp_q);
        end
        psu_pkg::CFG_BPP: begin
          bpp_q <= cfg_wdata_i[psu_pkg::BppW-1:0];
          len_q <= row_len(width_q, cfg_wdata_i[psu_pkg::BppW-1:0]);
        end
        default: begin
        end
      endcase
    end
  end

  assign bpp3 = (bpp_q == psu_pkg::BppW'(3));

  // ---------------------------------------------------------------------
  // Handshake
  // ---------------------------------------------------------------------
  logic s1_valid_q;
  logic out_valid_q;
  logic s1_fire;
  logic in_fire;
  logic pix_fire;
  logic await_eff;

  assign s1_fire    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_fire;
  assign in_fire    = in_valid_i && in_ready_o;

  // ---------------------------------------------------------------------
  // Row tracking at acceptance
  // ---------------------------------------------------------------------
  logic                  await_q;
  logic                  first_q;
  logic [ColW-1:0]       col_q;
  psu_pkg::filter_e      filt_q;
  logic                  last;
  logic [AddrW-1:0]      rd_addr;

  // A new image restarts the row; its word is always a filter type word.
  assign await_eff = await_q || in_data_i.image_start;
  assign pix_fire  = in_fire && !await_eff;
  assign last      = (LenW'(col_q) + LenW'(1)) >= len_q;
  assign rd_addr   = (LenW'(col_q) >= LenW'(Depth)) ? AddrW'(Depth - 1) : AddrW'(col_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      await_q <= 1'b1;
      first_q <= 1'b1;
      col_q   <= '0;
      filt_q  <= psu_pkg::FILT_NONE;
    end else if (in_fire) begin
      if (await_eff) begin
        // Filter type word: latch it, collapse unknown codes
        filt_q  <= (in_data_i.in_byte > 8'd4) ? psu_pkg::FILT_BAD
                                              : psu_pkg::filter_e'(in_data_i.in_byte[2:0]);
        await_q <= 1'b0;
        col_q   <= '0;
        if (in_data_i.image_start) begin
          first_q <= 1'b1;
        end
      end else if (last) begin
        await_q <= 1'b1;
        first_q <= 1'b0;
        col_q   <= '0;
      end else begin
        col_q <= col_q + ColW'(1);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Working stage
  // ---------------------------------------------------------------------
  logic [7:0]       s1_x_q;
  logic [ColW-1:0]  s1_col_q;
  logic [AddrW-1:0] s1_addr_q;
  logic             s1_last_q;
  logic             s1_first_q;
  psu_pkg::filter_e s1_filt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (pix_fire) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_fire) begin
      s1_x_q     <= in_data_i.in_byte;
      s1_col_q   <= col_q;
      s1_addr_q  <= rd_addr;
      s1_last_q  <= last;
      s1_first_q <= first_q;
      s1_filt_q  <= filt_q;
    end
  end

  // Line store: previous row, overwritten byte by byte as the new row passes
  logic [7:0] store_mem [Depth];
  logic [7:0] above_q;
  logic [7:0] recon;

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      store_mem[s1_addr_q] <= recon;
    end
    if (pix_fire) begin
      // Forward a write to the same entry in the same cycle
      if (s1_fire && (s1_addr_q == rd_addr)) begin
        above_q <= recon;
      end else begin
        above_q <= store_mem[rd_addr];
      end
    end
  end

  // Last four reconstructed bytes and last four above bytes of this row.
  // The first three bytes of a row (four unless bpp is three) see zero, which
  // stands for the clear at the row start.
  logic [31:0] left_hist_q;
  logic [31:0] ul_hist_q;
  logic        near_start;
  logic [7:0]  pa_left;
  logic [7:0]  pb_above;
  logic [7:0]  pc_ul;
  logic [7:0]  pred;
  logic [8:0]  sum_ab;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_hist_q <= '0;
      ul_hist_q   <= '0;
    end else if (s1_fire) begin
      left_hist_q <= {left_hist_q[23:0], recon};
      ul_hist_q   <= {ul_hist_q[23:0], pb_above};
    end
  end

  assign near_start = bpp3 ? (s1_col_q < ColW'(3)) : (s1_col_q < ColW'(4));
  assign pa_left    = near_start ? 8'd0 : (bpp3 ? left_hist_q[23:16] : left_hist_q[31:24]);
  assign pb_above   = s1_first_q ? 8'd0 : above_q;
  assign pc_ul      = (near_start || s1_first_q) ? 8'd0
                                                 : (bpp3 ? ul_hist_q[23:16] : ul_hist_q[31:24]);
  assign sum_ab     = 9'(pa_left) + 9'(pb_above);

  always_comb begin
    case (s1_filt_q)
      psu_pkg::FILT_SUB:   pred = pa_left;
      psu_pkg::FILT_UP:    pred = pb_above;
      psu_pkg::FILT_AVG:   pred = sum_ab[8:1];
      psu_pkg::FILT_PAETH: pred = paeth(pa_left, pb_above, pc_ul);
      default:             pred = 8'd0;
    endcase
  end

  assign recon = s1_x_q + pred;

  // ---------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------
  psu_pkg::out_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      out_q.pixel_byte <= recon;
      out_q.row_last   <= s1_last_q;
      out_q.filter_bad <= (s1_filt_q == psu_pkg::FILT_BAD);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_pix_enters_stage : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_fire |=> s1_valid_q)
    else $error("accepted pixel word did not reach the working stage");

  a_filter_skips_stage : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && await_eff) |=> (s1_valid_q == $past(s1_valid_q && !s1_fire)))
    else $error("filter type word entered the working stage");

  a_row_end_awaits : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pix_fire && last) |=> (await_q && (col_q == '0)))
    else $error("row end did not rearm the filter type word");

  a_stage_drains : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire |=> out_valid_q)
    else $error("working stage result lost before the output register");

endmodule
